@@ sv/pgwalk_pkg.sv @@
// Shared definitions for the four-level page-table walker:
// command and status codes, sequencer states, entry bit positions, index split.
`timescale 1ns / 1ps

package pgwalk_pkg;

  localparam int FRAMES_DEFAULT = 64;
  localparam int FRAMES_MAX     = 4096;

  localparam int LEVELS        = 4;
  localparam int INDEX_W       = 9;
  localparam int FRAME_SHIFT   = 12;
  localparam int PFRAME_W      = 52;
  localparam int PRESENT_BIT   = 0;
  localparam int USER_BIT      = 2;

  // Command codes
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_LOOKUP    = 2'd1;
  localparam logic [1:0] CMD_MARK_USER = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_RANGE       = 2'd2;

  localparam logic [1:0] LEAF_LEVEL = 2'(LEVELS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } walk_state_t;

  // Level 0 takes bits 35..27, level 3 (leaf) takes bits 8..0.
  function automatic logic [INDEX_W-1:0] level_index(input logic [35:0] vpage,
                                                     input logic [1:0]  level);
    logic [INDEX_W-1:0] idx;
    begin
      case (level)
        2'd0:    idx = vpage[35:27];
        2'd1:    idx = vpage[26:18];
        2'd2:    idx = vpage[17:9];
        default: idx = vpage[8:0];
      endcase
      return idx;
    end
  endfunction

endpackage

@@ sv/four_level_page_table_walker.sv @@
// Four-level radix page-table walker over a local table memory.
// Uses pgwalk_pkg for codes, states and the virtual page index split.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall): one command per transfer.
//     write entry : stores entry_value at entry_address; status 2 and no store
//                   when the address is FRAMES*512 or more.
//     lookup      : walks four levels from root_frame, returns the leaf frame
//                   (entry >> 12), status 1 on an absent entry, 2 on a bad frame.
//     make user   : same walk, sets bit 2 on present directories and the leaf.
//   Output channel (out_valid / out_stall): one status and physical_frame per
//   command. cfg_write loads root_frame; write it only with the walker idle.
// Timing
//   One single-port table memory with registered read data serves everything.
//   Each level passes through READ and EVAL (user-bit write-back rides EVAL).
//   A walk goes IDLE, READ/EVAL per level, then DONE, which raises out_valid
//   once the output register is free; a write, an unused command or a rejected
//   root goes from IDLE straight to DONE, an early stop from EVAL to DONE. One
//   command in flight; the walker is idle again as out_valid rises.
// Reset: rst (synchronous) starts a clearing pass over all FRAMES*512 words, in_stall high.
// Stall: a result waits in the output register while out_stall is high; the
//   next command may be walked meanwhile, its result held in the sequencer.

module four_level_page_table_walker
  import pgwalk_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [35:0] virtual_page,
  input  logic [14:0] entry_address,
  input  logic [63:0] entry_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [PFRAME_W-1:0] physical_frame
);

  localparam int DEPTH   = FRAMES * 512;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [PFRAME_W-1:0] FRAMES_P = PFRAME_W'(FRAMES);
  localparam logic [31:0]         DEPTH_W  = 32'(DEPTH);
  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Table memory, single port, registered read
  logic [63:0]        mem [DEPTH];
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [63:0]        mem_wdata;
  logic [63:0]        rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Control and payload registers
  walk_state_t        state;
  logic [5:0]         root_frame;
  logic [ADDR_W-1:0]  clr_addr;
  logic [1:0]         level;
  logic               mark;
  logic [35:0]        vpage;
  logic [FRAME_W-1:0] frame;
  logic [ADDR_W-1:0]  walk_addr;
  logic [1:0]         res_status;
  logic [PFRAME_W-1:0] res_frame;

  logic                in_xfer;
  logic                out_free;
  logic [12:0]         root_ext;
  logic [31:0]         eaddr_ext;
  logic                root_oor;
  logic                eaddr_oor;
  logic [FRAME_W+8:0]  walk_addr_full;
  logic [ADDR_W-1:0]   walk_addr_next;
  logic                present;
  logic                dir_oor;
  logic [63:0]         marked_word;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  assign root_ext  = {7'd0, root_frame};
  assign eaddr_ext = {17'd0, entry_address};
  assign root_oor  = (root_ext >= 13'(FRAMES));
  assign eaddr_oor = (eaddr_ext >= DEPTH_W);

  // frame*512 + index is a plain concatenation
  assign walk_addr_full = {frame, level_index(vpage, level)};
  assign walk_addr_next = walk_addr_full[ADDR_W-1:0];

  assign present     = rd_data[PRESENT_BIT];
  assign dir_oor     = (rd_data[63:FRAME_SHIFT] >= FRAMES_P);
  assign marked_word = rd_data | (64'd1 << USER_BIT);

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = walk_addr;
    mem_wdata = marked_word;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 64'd0;
      end
      S_IDLE: begin
        mem_we    = in_xfer && (command == CMD_WRITE) && !eaddr_oor;
        mem_addr  = eaddr_ext[ADDR_W-1:0];
        mem_wdata = entry_value;
      end
      S_READ: begin
        mem_re   = 1'b1;
        mem_addr = walk_addr_next;
      end
      S_EVAL: begin
        // user-bit write-back; directory entries only when present
        mem_we = mark && (present || (level == LEAF_LEVEL));
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      root_frame <= 6'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        root_frame <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            vpage      <= virtual_page;
            level      <= 2'd0;
            mark       <= (command == CMD_MARK_USER);
            frame      <= root_ext[FRAME_W-1:0];
            res_status <= ST_OK;
            res_frame  <= '0;
            state      <= S_DONE;
            case (command) inside
              CMD_WRITE: begin
                if (eaddr_oor) begin
                  res_status <= ST_RANGE;
                end
              end
              CMD_LOOKUP, CMD_MARK_USER: begin
                if (root_oor) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          walk_addr <= walk_addr_next;
          state     <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_DONE;
          if (level != LEAF_LEVEL) begin
            if (!present) begin
              res_status <= ST_NOT_PRESENT;
            end else if (dir_oor) begin
              res_status <= ST_RANGE;
            end else begin
              frame <= rd_data[FRAME_SHIFT +: FRAME_W];
              level <= level + 1'b1;
              state <= S_READ;
            end
          end else if (!mark) begin
            if (!present) begin
              res_status <= ST_NOT_PRESENT;
            end else begin
              res_frame <= rd_data[63:FRAME_SHIFT];
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            physical_frame <= res_frame;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for four_level_page_table_walker: builds page tables,
// walks and marks them, and checks every status and physical_frame.
// Depends on pgwalk_pkg and the walker RTL only.
`timescale 1ns / 1ps

module testbench;
  import pgwalk_pkg::*;

  localparam int N_FRAMES   = FRAMES_DEFAULT;
  localparam int N_WORDS    = N_FRAMES * 512;
  localparam int N_ITEMS    = 1950;
  // Clearing pass after reset plus a very pessimistic per-transfer budget.
  localparam int CYCLE_CAP  = N_WORDS + N_ITEMS * 160 + 20000;
  localparam int TAIL_WAIT  = 16;   // idle cycles after the final drain
  localparam int PHASE_LEN  = 350;  // random transfers between root changes

  // Command 3 has no name in the package; the walker just answers OK.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [PFRAME_W-1:0] frame;
  } walk_result_t;

  // Scoreboard: shadow table memory, root register, and results in flight.
  class walker_scoreboard;
    logic [63:0]  words [N_WORDS];
    int           root;
    walk_result_t walk_results_due[$];
    int           errors, checked, mapped, faults, out_of_range;

    function new();
      foreach (words[i]) words[i] = '0;
      root = 0;
    endfunction

    // Walks the three directory levels; sets the user bit on the way when
    // marking. Returns the status and the leaf word address.
    function logic [1:0] walk_path(logic [35:0] vp, bit mark, output int leaf);
      int          frame;
      int          addr;
      logic [63:0] word;
      leaf  = 0;
      frame = root;
      if (frame >= N_FRAMES) return ST_RANGE;
      for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
        addr = frame * 512 + int'(vp[35 - 9 * lvl -: 9]);
        word = words[addr];
        if (!word[PRESENT_BIT]) return ST_NOT_PRESENT;
        if (mark) words[addr][USER_BIT] = 1'b1;
        if (word[63:FRAME_SHIFT] >= N_FRAMES) return ST_RANGE;
        frame = int'(word[63:FRAME_SHIFT]);
      end
      leaf = frame * 512 + int'(vp[8:0]);
      return ST_OK;
    endfunction

    function void note_command(logic [1:0] cmd, logic [35:0] vp,
                               logic [14:0] ea, logic [63:0] ev);
      walk_result_t r;
      int           leaf;
      r.status = ST_OK;
      r.frame  = '0;
      case (cmd)
        CMD_WRITE: begin
          if (ea < N_WORDS) words[ea] = ev;
          else r.status = ST_RANGE;
        end
        CMD_LOOKUP: begin
          r.status = walk_path(vp, 1'b0, leaf);
          if (r.status == ST_OK) begin
            if (!words[leaf][PRESENT_BIT]) r.status = ST_NOT_PRESENT;
            else r.frame = words[leaf][63:FRAME_SHIFT];
          end
          if (r.status == ST_OK) mapped++;
        end
        CMD_MARK_USER: begin
          r.status = walk_path(vp, 1'b1, leaf);
          if (r.status == ST_OK) words[leaf][USER_BIT] = 1'b1;
        end
        default: ;
      endcase
      if (r.status == ST_NOT_PRESENT) faults++;
      if (r.status == ST_RANGE) out_of_range++;
      walk_results_due.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [PFRAME_W-1:0] pf);
      walk_result_t want;
      checked++;
      if (walk_results_due.size() == 0) begin
        $error("unrequested result: status %0d physical_frame 0x%0h", st, pf);
        errors++;
        return;
      end
      want = walk_results_due.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (pf !== want.frame) begin
        $error("physical_frame: expected 0x%0h, got 0x%0h", want.frame, pf);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT hookup; every input is known from time zero.
  // ---------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [5:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          command = CMD_WRITE;
  logic [35:0]         virtual_page = '0;
  logic [14:0]         entry_address = '0;
  logic [63:0]         entry_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [PFRAME_W-1:0] physical_frame;

  four_level_page_table_walker #(
    .FRAMES(N_FRAMES)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .virtual_page   (virtual_page),
    .entry_address  (entry_address),
    .entry_value    (entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .physical_frame (physical_frame)
  );

  walker_scoreboard sb;
  bit               calm = 1'b0;   // no idling on either side while set
  int               cycles = 0;
  int               n_sent = 0;
  int               n_cmd [4];
  int               n_roots = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: stalls about a third of the cycles, except in the calm window.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
  end

  // Result monitor and run limit. Signals read here are the values the DUT
  // saw at this edge, since the bench only drives with nonblocking updates.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(status, physical_frame);
  end

  // One command transfer: optional idle gap, present the payload, hold it
  // until the walker stops stalling, then let the scoreboard predict it.
  // Valid stays high on return so back-to-back transfers need no re-raise.
  task automatic send(input logic [1:0] cmd, input logic [35:0] vp,
                      input logic [14:0] ea, input logic [63:0] ev);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    virtual_page  <= vp;
    entry_address <= ea;
    entry_value   <= ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(cmd, vp, ea, ev);
    n_sent++;
    n_cmd[cmd]++;
  endtask

  // Sender holds off until every outstanding result has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.walk_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Root register only changes with the walker idle.
  task automatic set_root(input logic [5:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.root = int'(v);
    n_roots++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Directory word pointing at frame nf, present, random flag bits.
  function automatic logic [63:0] dir_word(input int nf);
    return {52'(nf), 12'($urandom) | 12'h001};
  endfunction

  // Writes the missing entries, up to four, that map vp under the current root. Present,
  // in-range directories are reused half the time so paths share tables.
  // A broken path may get a hole or a directory pointing past the frames.
  task automatic build_path(input logic [35:0] vp, input bit broken);
    int          f;
    int          addr;
    logic [63:0] w;
    f = sb.root;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      addr = f * 512 + int'(vp[35 - 9 * lvl -: 9]);
      w    = sb.words[addr];
      if (w[PRESENT_BIT] && w[63:FRAME_SHIFT] < N_FRAMES && $urandom_range(1)) begin
        f = int'(w[63:FRAME_SHIFT]);
      end else begin
        w = dir_word($urandom_range(N_FRAMES - 1));
        if (broken && $urandom_range(3) == 0) w[PRESENT_BIT] = 1'b0;
        else if (broken && $urandom_range(3) == 0)
          w[63:FRAME_SHIFT] = 52'(rand64()) | (52'd1 << $urandom_range(51, 6));
        send(CMD_WRITE, 36'(rand64()), 15'(addr), w);
        if (!w[PRESENT_BIT] || w[63:FRAME_SHIFT] >= N_FRAMES) return;
        f = int'(w[63:FRAME_SHIFT]);
      end
    end
    w = rand64();
    w[PRESENT_BIT] = broken ? 1'($urandom) : 1'b1;
    send(CMD_WRITE, 36'(rand64()), 15'(f * 512 + int'(vp[8:0])), w);
  endtask

  initial begin
    logic [35:0] vp_top;
    logic [35:0] pool [8];
    logic [35:0] vp;
    logic [5:0]  root_plan [5];
    int          phase;
    int          n_ops;
    int          pick;

    sb = new();
    foreach (n_cmd[i]) n_cmd[i] = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // The clearing pass holds in_stall high; the first send just waits.

    // ----- directed part, root frame 0 ------------------------------------
    // All-ones page: every index is 0x1ff, path 0 -> 1 -> 2 -> 63.
    vp_top = '1;
    send(CMD_LOOKUP,    vp_top, '0, '0);              // empty table: not present
    send(CMD_MARK_USER, '0,     '0, '0);              // stops at the top level
    send(CMD_UNUSED,    '1,     '1, '1);              // unused command: OK, no effect
    send(CMD_WRITE, '0, 15'd511,  {52'd1,  12'h001});
    send(CMD_WRITE, '0, 15'd1023, {52'd2,  12'hfff});
    send(CMD_WRITE, '0, 15'd1535, {52'd63, 12'h001});
    send(CMD_LOOKUP,    vp_top, '0, '0);              // leaf absent
    send(CMD_MARK_USER, vp_top, '0, '0);              // leaf marked regardless
    send(CMD_WRITE, '1, 15'h7fff, 64'hffff_ffff_ffff_f001); // top address, max leaf frame
    send(CMD_LOOKUP,    vp_top, '0, '0);              // leaf frame not range checked
    send(CMD_MARK_USER, vp_top, '0, '0);
    send(CMD_LOOKUP,    vp_top, '1, '1);
    // Directory pointing past the last frame, one level down.
    send(CMD_WRITE, '0, 15'd512, '1);
    send(CMD_LOOKUP,    {9'h1ff, 27'h0}, '0, '0);
    send(CMD_MARK_USER, {9'h1ff, 27'h0}, '0, '0);     // bit set, then range stop
    // Hole at level two: make-user stops with earlier levels marked.
    send(CMD_WRITE, '0, 15'd1024, '0);
    send(CMD_LOOKUP,    {9'h1ff, 9'h1ff, 18'h0}, '0, '0);
    send(CMD_MARK_USER, {9'h1ff, 9'h1ff, 18'h0}, '0, '0);
    // Address zero, directory exactly FRAMES.
    send(CMD_WRITE, '0, '0, {52'(N_FRAMES), 12'h001});
    send(CMD_LOOKUP, '0, '0, '0);
    send(CMD_WRITE, '0, '0, {52'd63, 12'h001});
    send(CMD_LOOKUP, '0, '0, '0);                     // stops at an empty level-1 entry

    // ----- random part ----------------------------------------------------
    // Root changes hit both extremes; each one drains the walker first.
    root_plan[0] = 6'd63;
    root_plan[1] = 6'd0;
    root_plan[2] = 6'($urandom);
    root_plan[3] = 6'd63;
    root_plan[4] = 6'($urandom);
    phase = 0;
    foreach (pool[i]) pool[i] = 36'(rand64());

    while (n_sent < N_ITEMS) begin
      if (n_sent >= 22 + PHASE_LEN * (phase + 1) && phase < 5) begin
        set_root(root_plan[phase]);
        phase++;
      end
      calm <= (n_sent >= 800 && n_sent < 1100);

      pick = $urandom_range(99);
      if (pick < 75) begin
        // Mostly well-formed: often (re)build a path, then walk and mark it or a
        // neighbor page that shares the leaf table.
        if ($urandom_range(7) == 0) pool[$urandom_range(7)] = 36'(rand64());
        vp = pool[$urandom_range(7)];
        if ($urandom_range(99) < 60) build_path(vp, $urandom_range(4) == 0);
        n_ops = $urandom_range(3, 1);
        repeat (n_ops) begin
          if ($urandom_range(3) == 0) vp[8:0] = 9'($urandom);
          send($urandom_range(9) < 5 ? CMD_LOOKUP : CMD_MARK_USER,
               vp, 15'($urandom), rand64());
        end
      end else begin
        // Noise: any command, any field value.
        send(2'($urandom), 36'(rand64()), 15'($urandom), rand64());
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d commands: %0d writes, %0d lookups, %0d make-user, %0d unused",
             n_sent, n_cmd[CMD_WRITE], n_cmd[CMD_LOOKUP], n_cmd[CMD_MARK_USER],
             n_cmd[CMD_UNUSED]);
    $display("%0d results checked over %0d root settings: %0d mapped, %0d absent, %0d range",
             sb.checked, n_roots + 1, sb.mapped, sb.faults, sb.out_of_range);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pgwalk_pkg.sv
sv/four_level_page_table_walker.sv
tb/sv/testbench.sv
